[hw/rtl/text_chunk_break_finder_core_macros.svh]
// assertion helpers for the chunk break finder
`ifndef TEXT_CHUNK_BREAK_FINDER_CORE_MACROS_SVH
`define TEXT_CHUNK_BREAK_FINDER_CORE_MACROS_SVH

// clocked check, off while reset is held
`define TCBF_ASSERT_SYNC(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// same-cycle implication
`define TCBF_ASSERT_IMPLY(label, ante, cons, msg) \
    `TCBF_ASSERT_SYNC(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/tcbf_pkg.sv]
package tcbf_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHUNK_W     = 13;
    localparam int SEP_W       = 2;
    localparam int ADV_W       = 14;
    localparam int KIND_W      = 3;
    localparam int NUM_BREAKS  = 5;
    localparam int MAX_WINDOW  = 8191;
    localparam int WINDOW_RESET = 256;
    localparam int QUEUE_DEPTH = 2;
    localparam int RESULT_W    = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_REST   = 3'd0,
        KIND_BLANK  = 3'd1,
        KIND_NL     = 3'd2,
        KIND_SENT   = 3'd3,
        KIND_CLAUSE = 3'd4,
        KIND_SPACE  = 3'd5,
        KIND_HARD   = 3'd6
    } break_kind_t;

    // tracker slots, one per separator break kind (rest and hard cut have none)
    localparam int BRK_BLANK  = 0;
    localparam int BRK_NL     = 1;
    localparam int BRK_SENT   = 2;
    localparam int BRK_CLAUSE = 3;
    localparam int BRK_SPACE  = 4;

    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
    localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

    // lowest field in the lowest bits
    typedef struct packed {
        break_kind_t        break_kind;
        logic [ADV_W-1:0]   advance;
        logic [SEP_W-1:0]   sep_len;
        logic [CHUNK_W-1:0] text_len;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

endpackage

[hw/rtl/tcbf_front.sv]
module tcbf_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic [tcbf_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           in_final,
    input  logic                           cfg_we,
    input  logic [tcbf_pkg::CHUNK_W-1:0]   cfg_data,
    output tcbf_pkg::push_t                push
);
    import tcbf_pkg::*;

    logic [CHUNK_W-1:0]    win_len_reg, win_len_next;
    logic [CHUNK_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]     prev_reg, prev_next;
    logic [NUM_BREAKS-1:0] seen_reg, seen_next;
    logic                  decided_reg, decided_next;
    logic [CHUNK_W-1:0]    pos_reg [NUM_BREAKS];
    logic [CHUNK_W-1:0]    pos_next [NUM_BREAKS];

    logic [CHUNK_W-1:0]    win;
    logic [CHUNK_W-1:0]    pos_upd [NUM_BREAKS];
    logic [NUM_BREAKS-1:0] seen_upd;
    logic [NUM_BREAKS-1:0] seen_fin;
    logic [CHUNK_W-1:0]    pos_fin [NUM_BREAKS];
    logic                  at_limit;
    logic                  prev_is_end, prev_is_clause, cur_is_blank;
    result_t               res;
    logic [CHUNK_W-1:0]    sel_len;
    logic [SEP_W-1:0]      sel_sep;
    break_kind_t           sel_kind;

    always_comb begin
        if (win_len_reg == '0) begin
            win = CHUNK_W'(1);
        end else if (int'(win_len_reg) > MAX_WINDOW) begin
            win = CHUNK_W'(MAX_WINDOW);
        end else begin
            win = win_len_reg;
        end
    end

    assign at_limit = (count_reg >= win - CHUNK_W'(1));

    assign prev_is_end    = (prev_reg == CH_DOT) || (prev_reg == CH_BANG)
                         || (prev_reg == CH_QUEST);
    assign prev_is_clause = (prev_reg == CH_COMMA) || (prev_reg == CH_SEMI);
    assign cur_is_blank   = (in_byte == CH_SPACE) || (in_byte == CH_TAB);

    // breaks at the previous position, now that its next byte is known
    // (a cleared previous byte never matches, so the first byte needs no guard)
    always_comb begin
        for (int k = 0; k < NUM_BREAKS; k++) begin
            pos_upd[k] = pos_reg[k];
        end
        seen_upd = seen_reg;
        if (prev_reg == CH_NL && in_byte == CH_NL) begin
            pos_upd[BRK_BLANK] = count_reg - CHUNK_W'(1);
            seen_upd[BRK_BLANK] = 1'b1;
        end
        if (prev_reg == CH_NL) begin
            pos_upd[BRK_NL] = count_reg - CHUNK_W'(1);
            seen_upd[BRK_NL] = 1'b1;
        end
        if (prev_is_end && cur_is_blank) begin
            pos_upd[BRK_SENT] = count_reg;
            seen_upd[BRK_SENT] = 1'b1;
        end
        if (prev_is_clause && in_byte == CH_SPACE) begin
            pos_upd[BRK_CLAUSE] = count_reg;
            seen_upd[BRK_CLAUSE] = 1'b1;
        end
        if (prev_reg == CH_SPACE) begin
            pos_upd[BRK_SPACE] = count_reg - CHUNK_W'(1);
            seen_upd[BRK_SPACE] = 1'b1;
        end
    end

    // last window byte, followed by nul: only newline and space can fire
    always_comb begin
        for (int k = 0; k < NUM_BREAKS; k++) begin
            pos_fin[k] = pos_upd[k];
        end
        seen_fin = seen_upd;
        if (in_byte == CH_NL) begin
            pos_fin[BRK_NL] = count_reg;
            seen_fin[BRK_NL] = 1'b1;
        end
        if (in_byte == CH_SPACE) begin
            pos_fin[BRK_SPACE] = count_reg;
            seen_fin[BRK_SPACE] = 1'b1;
        end
    end

    // best kind wins: walk from weakest to strongest
    always_comb begin
        sel_len  = win;
        sel_sep  = '0;
        sel_kind = KIND_HARD;
        for (int k = NUM_BREAKS - 1; k >= 0; k--) begin
            if (seen_fin[k]) begin
                sel_len  = pos_fin[k];
                sel_sep  = (k == BRK_BLANK) ? SEP_W'(2) : SEP_W'(1);
                sel_kind = break_kind_t'(KIND_W'(k + 1));
            end
        end
    end

    always_comb begin
        if (in_final) begin
            res.text_len   = count_reg + CHUNK_W'(1);
            res.sep_len    = '0;
            res.break_kind = KIND_REST;
        end else begin
            res.text_len   = sel_len;
            res.sep_len    = sel_sep;
            res.break_kind = sel_kind;
        end
        res.advance = ADV_W'(res.text_len) + ADV_W'(res.sep_len);
    end

    always_comb begin
        push.valid = in_valid && !cfg_we && !decided_reg && (in_final || at_limit);
        push.res   = res;
    end

    always_comb begin
        win_len_next = win_len_reg;
        count_next   = count_reg;
        prev_next    = prev_reg;
        seen_next    = seen_reg;
        decided_next = decided_reg;
        for (int k = 0; k < NUM_BREAKS; k++) begin
            pos_next[k] = pos_reg[k];
        end
        if (cfg_we) begin
            win_len_next = cfg_data;
            count_next   = '0;
            prev_next    = '0;
            seen_next    = '0;
            decided_next = 1'b0;
        end else if (in_valid) begin
            if (in_final) begin
                count_next   = '0;
                prev_next    = '0;
                seen_next    = '0;
                decided_next = 1'b0;
            end else if (!decided_reg) begin
                if (at_limit) begin
                    decided_next = 1'b1;
                end else begin
                    count_next = count_reg + CHUNK_W'(1);
                    prev_next  = in_byte;
                    seen_next  = seen_upd;
                    for (int k = 0; k < NUM_BREAKS; k++) begin
                        pos_next[k] = pos_upd[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg <= CHUNK_W'(WINDOW_RESET);
            count_reg   <= '0;
            prev_reg    <= '0;
            seen_reg    <= '0;
            decided_reg <= 1'b0;
        end else begin
            win_len_reg <= win_len_next;
            count_reg   <= count_next;
            prev_reg    <= prev_next;
            seen_reg    <= seen_next;
            decided_reg <= decided_next;
        end
    end

    // positions only matter behind a seen bit
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_BREAKS; k++) begin
            pos_reg[k] <= pos_next[k];
        end
    end

endmodule

[hw/rtl/tcbf_result_queue.sv]
module tcbf_result_queue #(
    parameter int DEPTH = tcbf_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tcbf_pkg::push_t   push,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output tcbf_pkg::result_t out_res
);
    import tcbf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push.valid && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push.valid) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.res;
        end
    end

endmodule

[hw/rtl/text_chunk_break_finder_core.sv]
// chunk break finder
// s_ channel: one text byte per transaction, s_tlast on the final byte of the text.
// m_ channel: one result per decision: chunk length, separator length, advance
// and break kind (whole rest, blank line, newline, sentence, clause, space, hard cut).
// cfg channel: writes the window length in bytes; a write also drops any text in
// progress, the next byte starts a new text. cfg_ready is always high.
// throughput: one byte per cycle while the result queue is not full, set by the byte tracker in the front.
// a result is written into the result queue registers on the transaction of the byte
// that decides it (the final byte, or the last window byte of a longer text).
// bytes after a decision are dropped until s_tlast; they give no result.
// results wait in a QUEUE_DEPTH-entry queue; while it is full s_tready is low, so a
// stalled receiver holds off the input side without losing anything.
// reset: window length 256, queue empty, stream state cleared.
`include "text_chunk_break_finder_core_macros.svh"

module text_chunk_break_finder_core #(
    parameter int QUEUE_DEPTH = tcbf_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // [7:0] text_byte
    input  logic [7:0]                       s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [12:0] text_len, [14:13] sep_len, [28:15] advance, [31:29] break_kind
    output logic [tcbf_pkg::RESULT_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tcbf_pkg::CHUNK_W-1:0]     cfg_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready
);
    import tcbf_pkg::*;

    logic    q_full;
    logic    s_xfer;
    push_t   push;
    result_t m_res;

    logic [ADV_W-1:0] adv_sum;
    logic             kind_blank, sep_two, kind_no_sep;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tdata   = m_res;

    tcbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_xfer),
        .in_byte   (s_tdata),
        .in_final  (s_tlast),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    tcbf_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res)
    );

    assign adv_sum     = ADV_W'(m_res.text_len) + ADV_W'(m_res.sep_len);
    assign kind_blank  = (m_res.break_kind == KIND_BLANK);
    assign sep_two     = (m_res.sep_len == SEP_W'(2));
    assign kind_no_sep = (m_res.break_kind == KIND_REST) || (m_res.break_kind == KIND_HARD);

    `TCBF_ASSERT_IMPLY(a_advance_sum, m_tvalid, m_res.advance == adv_sum, "advance mismatch")
    `TCBF_ASSERT_IMPLY(a_blank_sep, m_tvalid, kind_blank == sep_two, "two-byte sep off blank line")
    `TCBF_ASSERT_IMPLY(a_no_sep, m_tvalid && kind_no_sep, m_res.sep_len == '0, "sep on rest or cut")
    `TCBF_ASSERT_IMPLY(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result pending")

endmodule

[test/chunk_break_checker.sv]
`timescale 1ns / 100ps

module chunk_break_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [tcbf_pkg::RESULT_W-1:0] m_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tcbf_pkg::CHUNK_W-1:0]  cfg_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    output int                            error_count,
    output int                            pending_count
);
    import tcbf_pkg::*;

    localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

    logic [CHUNK_W-1:0]    window_reg = CHUNK_W'(WINDOW_RESET);
    logic [ADV_W-1:0]      text_pos;
    logic [BYTE_W-1:0]     prev_byte;
    logic [CHUNK_W-1:0]    brk_pos [NUM_BREAKS];
    logic [NUM_BREAKS-1:0] brk_seen;
    logic                  decided;
    result_t               expected_chunks [$];

    task automatic clear_text();
        text_pos  = '0;
        prev_byte = '0;
        brk_seen  = '0;
        decided   = 1'b0;
        for (int s = 0; s < NUM_BREAKS; s++) brk_pos[s] = '0;
    endtask

    task automatic note_break(input int slot, input logic [ADV_W-1:0] pos);
        brk_pos[slot]  = pos[CHUNK_W-1:0];
        brk_seen[slot] = 1'b1;
    endtask

    // byte c at position p, followed by byte n
    task automatic scan_pair(input logic [ADV_W-1:0] p, input logic [BYTE_W-1:0] c,
                             input logic [BYTE_W-1:0] n);
        if (c == CH_NL && n == CH_NL) note_break(BRK_BLANK, p);
        if (c == CH_NL) note_break(BRK_NL, p);
        if ((c == CH_DOT || c == CH_BANG || c == CH_QUEST) && (n == CH_SPACE || n == CH_TAB))
            note_break(BRK_SENT, p + ADV_W'(1));
        if ((c == CH_COMMA || c == CH_SEMI) && n == CH_SPACE)
            note_break(BRK_CLAUSE, p + ADV_W'(1));
        if (c == CH_SPACE) note_break(BRK_SPACE, p);
    endtask

    task automatic push_chunk(input logic [ADV_W-1:0] len, input logic [SEP_W-1:0] sep,
                              input break_kind_t kind);
        result_t r;
        r.text_len   = len[CHUNK_W-1:0];
        r.sep_len    = sep;
        r.advance    = len + sep;
        r.break_kind = kind;
        expected_chunks.push_back(r);
    endtask

    task automatic track_byte(input logic [BYTE_W-1:0] cur, input logic fin);
        logic [ADV_W-1:0] win;
        logic [ADV_W-1:0] idx;
        win = (window_reg == '0) ? ADV_W'(1) : ADV_W'(window_reg);
        if (win > ADV_W'(MAX_WINDOW)) win = ADV_W'(MAX_WINDOW);
        idx = text_pos;
        if (decided) begin
            if (fin) clear_text();
            return;
        end
        if (idx != '0) scan_pair(idx - ADV_W'(1), prev_byte, cur);
        if (fin) begin
            push_chunk(idx + ADV_W'(1), 2'd0, KIND_REST);
            clear_text();
            return;
        end
        if (idx + ADV_W'(1) >= win) begin
            // text is longer than the window: decide now, NUL seen past the window
            scan_pair(idx, cur, NUL_BYTE);
            decided = 1'b1;
            for (int s = BRK_BLANK; s <= BRK_SPACE; s++) begin
                if (brk_seen[s]) begin
                    push_chunk(ADV_W'(brk_pos[s]), (s == BRK_BLANK) ? 2'd2 : 2'd1,
                               break_kind_t'(KIND_W'(s + 1)));
                    return;
                end
            end
            push_chunk(win, 2'd0, KIND_HARD);
        end else begin
            prev_byte = cur;
            text_pos  = idx + ADV_W'(1);
        end
    endtask

    task automatic check_field(input string name, input int want, input int seen);
        if (want != seen) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endtask

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            window_reg = CHUNK_W'(WINDOW_RESET);
            clear_text();
            expected_chunks.delete();
            pending_count <= 0;
        end else begin
            // compare before pushing: a result never leaves in its own byte's cycle
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata);
                if (expected_chunks.size() == 0) begin
                    error_count++;
                    $display("%0t: result transaction, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = expected_chunks.pop_front();
                    check_field("text_len", want.text_len, got.text_len);
                    check_field("sep_len", want.sep_len, got.sep_len);
                    check_field("advance", want.advance, got.advance);
                    check_field("break_kind", want.break_kind, got.break_kind);
                end
            end
            if (cfg_valid && cfg_ready) begin
                window_reg = cfg_data;
                clear_text();
            end
            if (s_tvalid && s_tready) track_byte(s_tdata, s_tlast);
            pending_count <= expected_chunks.size();
        end
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import tcbf_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                s_tvalid;
    logic                s_tready;
    logic [RESULT_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [CHUNK_W-1:0]  cfg_data;
    logic                cfg_valid;
    logic                cfg_ready;

    int mismatches;
    int outstanding;
    int tx_idle_pct;
    int rx_idle_pct;
    int window_now;
    int byte_total;

    text_chunk_break_finder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    chunk_break_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .cfg_data      (cfg_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .error_count   (mismatches),
        .pending_count (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #40_000_000;
        $display("testbench: errors");
        $finish;
    end

    // heavy on separators so every break kind turns up often
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 14) return CH_NL;
        if (r < 30) return CH_SPACE;
        if (r < 34) return CH_DOT;
        if (r < 38) return CH_BANG;
        if (r < 42) return CH_QUEST;
        if (r < 47) return CH_COMMA;
        if (r < 52) return CH_SEMI;
        if (r < 56) return CH_TAB;
        if (r < 66) return 8'($urandom_range(255));
        return 8'($urandom_range(8'h61, 8'h7a));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_word(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
    endtask

    task automatic send_text(input int len, input bit ends, input bit plain);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (plain) b = 8'($urandom_range(8'h61, 8'h7a));
            else b = pick_char();
            send_byte(b, ends && (i == len - 1));
            byte_total++;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_window(input int w);
        cfg_data  <= w[CHUNK_W-1:0];
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        window_now = (w == 0) ? 1 : w;
    endtask

    initial begin : stimulus
        int r;
        int w;
        int len;
        int cap;
        aresetn     = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        s_tvalid    = 1'b0;
        cfg_data    = '0;
        cfg_valid   = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        window_now  = WINDOW_RESET;
        byte_total  = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // single-byte texts at the reset window
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        // open text, dropped by the window write
        send_byte(8'h61, 1'b0);
        send_byte(CH_NL, 1'b0);
        wait_drained();
        write_window(2);
        send_word("\n\nx");
        send_word("a\nx");
        send_word(". x");
        send_word("?\tx");
        send_word(", x");
        send_word("a x");
        send_word("abx");
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 78 : 0;
            rx_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 30 : 0;
            while (byte_total < 475 * (ph + 1)) begin
                r = $urandom_range(99);
                if (r < 6) w = 0;
                else if (r < 14) w = 1;
                else if (r < 22) w = 2;
                else if (r < 27) w = MAX_WINDOW;
                else if (r < 35) w = $urandom_range(100, 400);
                else w = $urandom_range(3, 24);
                write_window(w);
                cap = (window_now > 300) ? 300 : window_now;
                repeat ($urandom_range(2, 6)) begin
                    if (window_now > 300 || $urandom_range(1)) len = $urandom_range(1, cap);
                    else len = window_now + $urandom_range(1, 6);
                    send_text(len, 1'b1, 1'b0);
                end
                // now and then leave a text open for the next window write to drop
                if ($urandom_range(99) < 15) send_text($urandom_range(1, cap), 1'b0, 1'b0);
                wait_drained();
            end
        end

        // window with no break in it: hard cut at the window length
        write_window(40);
        send_text(45, 1'b1, 1'b1);
        wait_drained();

        if (mismatches == 0) $display("testbench: clean");
        else $display("testbench: errors");
        $finish;
    end

endmodule
